// File: rtl/fuzzy_subsequence_scorer_macros.svh
// Assertion macros used by the checker file of the fuzzy subsequence scorer.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fss assertion failed");

`endif

// File: rtl/fss_pkg.sv
// Package for the fuzzy subsequence scorer: sizes, scoring constants, item types
// and the character helper functions. Depends on nothing.
`default_nettype none

package fss_pkg;

    localparam int QUERY_MAX  = 32;
    localparam int PATH_MAX   = 512;

    localparam int QA_W       = $clog2(QUERY_MAX);
    localparam int CUR_W      = $clog2(QUERY_MAX + 1);
    localparam int POS_W      = $clog2(PATH_MAX);
    localparam int PLEN_W     = $clog2(PATH_MAX + 1);

    localparam int CHAR_W     = 8;
    localparam int SLOT_W     = 5;
    localparam int QLEN_W     = 6;
    localparam int MPOS_W     = 9;
    localparam int SCORE_W    = 12;
    localparam int PTS_W      = 11;

    localparam int PTS_MATCH   = 10;
    localparam int PTS_ADJ     = 15;
    localparam int PTS_BOUND   = 20;
    localparam int EMPTY_SCORE = 100;
    localparam int CASE_OFFSET = 32;

    localparam int DIV10_MUL   = 3277;
    localparam int DIV10_SHIFT = 15;
    localparam int PROD_W      = PLEN_W + 13;

    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_UNDER   = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;

    typedef struct packed {
        logic                      is_final;
        logic [MPOS_W-1:0]         match_position;
        logic signed [SCORE_W-1:0] score;
        logic                      found;
    } result_t;

    typedef struct packed {
        logic    push_match;
        logic    push_final;
        result_t match_item;
        result_t final_item;
    } push_t;

    function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return c + CHAR_W'(CASE_OFFSET);
        end
        return c;
    endfunction

    function automatic logic is_boundary(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SLASH) || (c == CHAR_UNDER) || (c == CHAR_DASH) || (c == CHAR_DOT);
    endfunction

endpackage

`default_nettype wire

// File: rtl/fuzzy_subsequence_scorer.sv
// Fuzzy subsequence scorer top level: query length register, scan core and
// output queue. Depends on fss_pkg, fss_scan and fss_out_fifo.
//
// Takes one item per cycle, load or scan, while in_stall is low: the query
// character at the current cursor is prefetched from the query RAM every cycle,
// with a write to that same slot forwarded, so a match and the next byte never
// wait on each other. A byte yields up to two result items (match report, then
// final score) into a four-entry output queue; in_stall rises only while that
// queue holds fewer than two free entries. The query store needs no clearing
// after reset; query_length is written through cfg_valid/cfg_ready, always ready.
`default_nettype none

module fuzzy_subsequence_scorer
    import fss_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [QLEN_W-1:0]         cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      mode,
    input  wire logic [CHAR_W-1:0]         char_byte,
    input  wire logic [SLOT_W-1:0]         query_slot,
    input  wire logic                      path_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           is_final,
    output logic [MPOS_W-1:0]              match_position,
    output logic signed [SCORE_W-1:0]      score,
    output logic                           found
);

    logic [QLEN_W-1:0] query_length_reg, query_length_next;
    logic              accept;
    logic              pop;
    push_t             push;
    result_t           head;

    always_comb
    begin
        cfg_ready         = 1'b1;
        query_length_next = (cfg_valid && cfg_ready) ? cfg_data : query_length_reg;
        accept            = in_valid && !in_stall;
        pop               = out_valid && !out_stall;
        is_final          = head.is_final;
        match_position    = head.match_position;
        score             = head.score;
        found             = head.found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
        end
        else
        begin
            query_length_reg <= query_length_next;
        end
    end

    fss_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .char_byte   (char_byte),
        .query_slot  (query_slot),
        .path_end    (path_end),
        .query_length(query_length_reg),
        .push        (push)
    );

    fss_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .out_valid(out_valid),
        .head     (head),
        .near_full(in_stall)
    );

endmodule

`default_nettype wire

// File: rtl/fss_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; width and depth come from its parameters.
`default_nettype none

module fss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/fss_scan.sv
// Scan core: query store RAM with next-cursor prefetch and write forwarding,
// scan state registers and per-byte scoring. Depends on fss_pkg and fss_ram.
`default_nettype none

module fss_scan
    import fss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              mode,
    input  wire logic [CHAR_W-1:0] char_byte,
    input  wire logic [SLOT_W-1:0] query_slot,
    input  wire logic              path_end,
    input  wire logic [QLEN_W-1:0] query_length,
    output push_t                  push
);

    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CHAR_W-1:0] prev_reg, prev_next;
    logic [POS_W-1:0]  last_reg, last_next;
    logic              seen_reg, seen_next;
    logic [PTS_W-1:0]  points_reg, points_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [CHAR_W-1:0] fwd_data_reg;

    logic              we;
    logic [QA_W-1:0]   waddr;
    logic [QA_W-1:0]   raddr;
    logic [CHAR_W-1:0] rdata;

    logic [CUR_W-1:0]  qlen;
    logic [CHAR_W-1:0] qchar;
    logic              scan;
    logic              hit;
    logic              adjacent;
    logic [PTS_W-1:0]  pts;
    logic [PTS_W-1:0]  points_upd;
    logic [CUR_W-1:0]  cursor_upd;
    logic [PLEN_W-1:0] plen;
    logic [PROD_W-1:0] prod;
    logic signed [SCORE_W-1:0] score_raw;
    logic signed [SCORE_W-1:0] score_fin;
    logic              found_fin;

    fss_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(QUERY_MAX)
    ) u_query_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(char_byte),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        qlen  = (32'(query_length) > QUERY_MAX) ? CUR_W'(QUERY_MAX) : CUR_W'(query_length);
        qchar = fwd_hit_reg ? fwd_data_reg : rdata;
        scan  = accept && mode;
        we    = accept && !mode && (32'(query_slot) < QUERY_MAX);
        waddr = QA_W'(query_slot);

        hit      = scan && (cursor_reg < qlen) && (fold_lower(char_byte) == fold_lower(qchar));
        adjacent = seen_reg && ({1'b0, pos_reg} == ({1'b0, last_reg} + (POS_W + 1)'(1)));
        pts      = PTS_W'(PTS_MATCH)
                 + (adjacent ? PTS_W'(PTS_ADJ) : PTS_W'(0))
                 + (is_boundary(prev_reg) ? PTS_W'(PTS_BOUND) : PTS_W'(0));

        points_upd = hit ? points_reg + pts : points_reg;
        cursor_upd = hit ? cursor_reg + CUR_W'(1) : cursor_reg;

        cursor_next = cursor_reg;
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        last_next   = last_reg;
        seen_next   = seen_reg;
        points_next = points_reg;

        if (scan)
        begin
            prev_next = char_byte;
            if (32'(pos_reg) < PATH_MAX - 1)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (hit)
            begin
                last_next   = pos_reg;
                seen_next   = 1'b1;
                points_next = points_upd;
                cursor_next = cursor_upd;
            end
            if (path_end)
            begin
                cursor_next = '0;
                pos_next    = '0;
                prev_next   = CHAR_SLASH;
                last_next   = '0;
                seen_next   = 1'b0;
                points_next = '0;
            end
        end

        raddr        = cursor_next[QA_W-1:0];
        fwd_hit_next = we && (waddr == raddr);
    end

    // final score: points minus path length / 10, or EMPTY_SCORE for an empty query
    always_comb
    begin
        plen      = PLEN_W'(pos_reg) + PLEN_W'(1);
        prod      = PROD_W'(plen) * PROD_W'(DIV10_MUL);
        score_raw = $signed({1'b0, points_upd}) - $signed(SCORE_W'(prod >> DIV10_SHIFT));
        if (qlen == '0)
        begin
            score_fin = SCORE_W'(EMPTY_SCORE);
            found_fin = 1'b1;
        end
        else
        begin
            score_fin = score_raw;
            found_fin = (cursor_upd >= qlen) && !score_raw[SCORE_W-1];
        end
    end

    always_comb
    begin
        push.push_match                = hit;
        push.push_final                = scan && path_end;
        push.match_item.is_final       = 1'b0;
        push.match_item.match_position = MPOS_W'(pos_reg);
        push.match_item.score          = '0;
        push.match_item.found          = 1'b0;
        push.final_item.is_final       = 1'b1;
        push.final_item.match_position = '0;
        push.final_item.score          = score_fin;
        push.final_item.found          = found_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            pos_reg     <= '0;
            prev_reg    <= CHAR_SLASH;
            last_reg    <= '0;
            seen_reg    <= 1'b0;
            points_reg  <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            cursor_reg  <= cursor_next;
            pos_reg     <= pos_next;
            prev_reg    <= prev_next;
            last_reg    <= last_next;
            seen_reg    <= seen_next;
            points_reg  <= points_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= char_byte;
    end

endmodule

`default_nettype wire

// File: rtl/fss_out_fifo.sv
// Output queue for result items: takes up to two items a cycle, gives one per pop.
// Depends on fss_pkg for the item types and queue depth.
`default_nettype none

module fss_out_fifo
    import fss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    input  wire logic  pop,
    output logic       out_valid,
    output result_t    head,
    output logic       near_full
);

    result_t               entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]   count_reg, count_next;
    logic [OQ_PTR_W-1:0]   final_ptr;

    always_comb
    begin
        final_ptr   = wr_ptr_reg + OQ_PTR_W'(push.push_match);
        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push.push_match) + OQ_PTR_W'(push.push_final);
        rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
        count_next  = count_reg + OQ_CNT_W'(push.push_match) + OQ_CNT_W'(push.push_final)
                    - OQ_CNT_W'(pop);
        out_valid   = (count_reg != '0);
        head        = entry_reg[rd_ptr_reg];
        near_full   = (32'(count_reg) > OQ_DEPTH - 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_match)
        begin
            entry_reg[wr_ptr_reg] <= push.match_item;
        end
        if (push.push_final)
        begin
            entry_reg[final_ptr] <= push.final_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fss_checker.sv
// Port-level checker for the fuzzy subsequence scorer, bound to the top level.
// Depends on fss_pkg and the assertion macros header.
`default_nettype none

`include "fuzzy_subsequence_scorer_macros.svh"

module fss_checker
    import fss_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic                 is_final,
    input wire logic [MPOS_W-1:0]    match_position,
    input wire logic [SCORE_W-1:0]   score,
    input wire logic                 found
);

    `FSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(is_final) && $stable(match_position) && $stable(score) && $stable(found))
    `FSS_ASSERT_IMPLY(a_report_clean, clk, rst_n, out_valid && !is_final, (score == '0) && !found)
    `FSS_ASSERT_IMPLY(a_final_pos_zero, clk, rst_n, out_valid && is_final, match_position == '0)
    `FSS_ASSERT_IMPLY(a_found_nonneg, clk, rst_n, out_valid && found, is_final && !score[SCORE_W-1])

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (.*);

`default_nettype wire
